// ===== hw/rtl/nmit_pkg.sv =====
// Shared constants and types for the normal matrix inverse-transpose unit.
package nmit_pkg;

   localparam int unsigned NUM_ELEM = 9;
   localparam int unsigned NUM_COL  = 3;

   typedef logic [3:0] elem_idx_type;

   // cofactor i = m[a]*m[b] - m[c]*m[d], column-major element numbering
   localparam elem_idx_type CF_IDX [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      logic valid;
      logic singular;
      logic det_neg;
   } nmit_det_ctl_type;

endpackage

// ===== hw/rtl/nmit_cofactor.sv =====
// Two-stage cofactor pipeline: pair products, then differences.
module nmit_cofactor import nmit_pkg::*; #(
   parameter int W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  logic signed [W-1:0]  m_in [NUM_ELEM],
   output logic                 valid_out,
   output logic signed [2*W:0]  cof_out [NUM_ELEM],
   output logic signed [W-1:0]  col_out [NUM_COL]
);
   localparam int PW = 2 * W;
   localparam int CW = 2 * W + 1;

   logic signed [PW-1:0] pa_in [NUM_ELEM];
   logic signed [PW-1:0] pb_in [NUM_ELEM];
   logic signed [PW-1:0] pa_ff [NUM_ELEM];
   logic signed [PW-1:0] pb_ff [NUM_ELEM];
   logic signed [CW-1:0] cof_in [NUM_ELEM];
   logic signed [CW-1:0] cof_ff [NUM_ELEM];
   logic signed [W-1:0]  col1_ff [NUM_COL];
   logic signed [W-1:0]  col2_ff [NUM_COL];
   logic                 v1_ff;
   logic                 v2_ff;

   always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         pa_in[i]  = m_in[CF_IDX[i][0]] * m_in[CF_IDX[i][1]];
         pb_in[i]  = m_in[CF_IDX[i][2]] * m_in[CF_IDX[i][3]];
         cof_in[i] = CW'(pa_ff[i]) - CW'(pb_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         pa_ff[i]  <= pa_in[i];
         pb_ff[i]  <= pb_in[i];
         cof_ff[i] <= cof_in[i];
      end
      for (int j = 0; j < NUM_COL; j++) begin
         col1_ff[j] <= m_in[j];
         col2_ff[j] <= col1_ff[j];
      end
   end

   assign valid_out = v2_ff;
   assign cof_out   = cof_ff;
   assign col_out   = col2_ff;

endmodule

// ===== hw/rtl/nmit_det.sv =====
// Four-stage determinant pipeline: split products, recombine, sum, sign and magnitude.
module nmit_det import nmit_pkg::*; #(
   parameter int W = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  logic signed [2*W:0]     cof_in [NUM_ELEM],
   input  logic signed [W-1:0]     col_in [NUM_COL],
   output nmit_det_ctl_type        ctl_out,
   output logic signed [2*W:0]     cof_out [NUM_ELEM],
   output logic [3*W+2:0]          dmag_out
);
   localparam int CW = 2 * W + 1;
   localparam int L  = W + 1;          // low split of a cofactor
   localparam int LW = W + L + 1;      // low partial product
   localparam int HW = 2 * W;          // high partial product
   localparam int PW = 3 * W + 1;      // full m*c product
   localparam int DW = 3 * W + 3;      // determinant
   localparam int NST = 4;

   logic signed [LW-1:0] plo_ff [NUM_COL];
   logic signed [HW-1:0] phi_ff [NUM_COL];
   logic signed [PW-1:0] prod_ff [NUM_COL];
   logic signed [DW-1:0] det_ff;
   logic [DW-1:0]        dmag_ff;
   logic signed [CW-1:0] cofd_ff [NST][NUM_ELEM];
   logic [NST-1:0]       vld_ff;
   logic                 sng_ff;
   logic                 neg_ff;
   logic signed [LW-1:0] plo_in [NUM_COL];
   logic signed [HW-1:0] phi_in [NUM_COL];
   logic signed [PW-1:0] prod_in [NUM_COL];
   logic signed [DW-1:0] det_in;
   logic [DW-1:0]        dmag_in;

   always_comb begin
      for (int j = 0; j < NUM_COL; j++) begin
         plo_in[j]  = col_in[j] * $signed({1'b0, cof_in[j][L-1:0]});
         phi_in[j]  = col_in[j] * $signed(cof_in[j][CW-1:L]);
         prod_in[j] = (PW'(phi_ff[j]) <<< L) + PW'(plo_ff[j]);
      end
      det_in  = DW'(prod_ff[0]) + DW'(prod_ff[1]) + DW'(prod_ff[2]);
      dmag_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NST-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_COL; j++) begin
         plo_ff[j]  <= plo_in[j];
         phi_ff[j]  <= phi_in[j];
         prod_ff[j] <= prod_in[j];
      end
      det_ff  <= det_in;
      dmag_ff <= dmag_in;
      sng_ff  <= (det_ff == '0);
      neg_ff  <= det_ff[DW-1];
      for (int i = 0; i < NUM_ELEM; i++) begin
         cofd_ff[0][i] <= cof_in[i];
         for (int s = 1; s < NST; s++) begin
            cofd_ff[s][i] <= cofd_ff[s-1][i];
         end
      end
   end

   always_comb begin
      ctl_out.valid    = vld_ff[NST-1];
      ctl_out.singular = sng_ff;
      ctl_out.det_neg  = neg_ff;
   end

   assign cof_out  = cofd_ff[NST-1];
   assign dmag_out = dmag_ff;

endmodule

// ===== hw/rtl/nmit_divider.sv =====
// Nine-lane pipelined restoring divider with rounding, saturation and sign restore.
module nmit_divider import nmit_pkg::*; #(
   parameter int W = 24,
   parameter int F = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nmit_det_ctl_type        ctl_in,
   input  logic signed [2*W:0]     cof_in [NUM_ELEM],
   input  logic [3*W+2:0]          dmag_in,
   output logic                    valid_out,
   output logic signed [W-1:0]     q_out [NUM_ELEM],
   output logic                    singular_out,
   output logic                    saturated_out
);
   localparam int CW   = 2 * W + 1;
   localparam int DW   = 3 * W + 3;
   localparam int DDW  = DW + 1;               // 2*|D|
   localparam int RW   = DDW + 1;              // partial remainder
   localparam int K    = W + 1;                // quotient bits kept
   localparam int SH   = 2 * F + 1;
   localparam int AW   = CW + SH;
   localparam int NW   = ((AW > DW) ? AW : DW) + 1;
   localparam int CMPW = (NW > DDW) ? NW : DDW;

   logic [RW-1:0]   rem_ff [K+1][NUM_ELEM];
   logic [K-1:0]    nlo_ff [K+1][NUM_ELEM];
   logic            ovf_ff [K+1][NUM_ELEM];
   logic            neg_ff [K+1][NUM_ELEM];
   logic [DDW-1:0]  dd_ff  [K+1];
   logic            sng_ff [K+1];
   logic [K:0]      vld_ff;
   logic [RW-1:0]   rem_in [K+1][NUM_ELEM];
   logic [K-1:0]    nlo_in [K+1][NUM_ELEM];
   logic            ovf_in [NUM_ELEM];
   logic            neg_in [NUM_ELEM];
   logic [CW-1:0]   mag_w  [NUM_ELEM];
   logic [NW-1:0]   n2_w   [NUM_ELEM];
   logic [DDW-1:0]  dd_in;
   logic [RW-1:0]   trial;
   logic [K-1:0]    lim;
   logic [K-1:0]    qm;
   logic [K-1:0]    qs;
   logic signed [W-1:0] res_in [NUM_ELEM];
   logic            sat_in;
   logic signed [W-1:0] res_ff [NUM_ELEM];
   logic            sat_ff;
   logic            sng_out_ff;
   logic            vld_out_ff;

   // entry stage: rounded numerator 2*|C|*2^(2F) + |D| over divisor 2*|D|
   always_comb begin
      dd_in = {dmag_in, 1'b0};
      for (int j = 0; j < NUM_ELEM; j++) begin
         mag_w[j]  = cof_in[j][CW-1] ? CW'(-cof_in[j]) : CW'(cof_in[j]);
         n2_w[j]   = NW'({mag_w[j], {SH{1'b0}}}) + NW'(dmag_in);
         ovf_in[j] = CMPW'(n2_w[j] >> K) >= CMPW'(dd_in);
         neg_in[j] = cof_in[j][CW-1] ^ ctl_in.det_neg;
      end
   end

   // one quotient bit per stage; quotient shifts into the spent numerator bits
   always_comb begin
      trial = '0;
      for (int j = 0; j < NUM_ELEM; j++) begin
         rem_in[0][j] = RW'(n2_w[j] >> K);
         nlo_in[0][j] = n2_w[j][K-1:0];
      end
      for (int s = 1; s <= K; s++) begin
         for (int j = 0; j < NUM_ELEM; j++) begin
            trial = {rem_ff[s-1][j][RW-2:0], nlo_ff[s-1][j][K-1]};
            if (trial >= RW'(dd_ff[s-1])) begin
               rem_in[s][j] = trial - RW'(dd_ff[s-1]);
               nlo_in[s][j] = {nlo_ff[s-1][j][K-2:0], 1'b1};
            end else begin
               rem_in[s][j] = trial;
               nlo_in[s][j] = {nlo_ff[s-1][j][K-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      sat_in = 1'b0;
      lim    = '0;
      qm     = '0;
      qs     = '0;
      for (int j = 0; j < NUM_ELEM; j++) begin
         lim = neg_ff[K][j] ? (K'(1) << (W - 1)) : ((K'(1) << (W - 1)) - K'(1));
         if (ovf_ff[K][j] || nlo_ff[K][j] > lim) begin
            qm     = lim;
            sat_in = sat_in | ~sng_ff[K];
         end else begin
            qm = nlo_ff[K][j];
         end
         qs        = neg_ff[K][j] ? (~qm + K'(1)) : qm;
         res_in[j] = sng_ff[K] ? '0 : $signed(qs[W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         vld_out_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[K-1:0], ctl_in.valid};
         vld_out_ff <= vld_ff[K];
      end
   end

   always_ff @(posedge clock) begin
      dd_ff[0]  <= dd_in;
      sng_ff[0] <= ctl_in.singular;
      for (int j = 0; j < NUM_ELEM; j++) begin
         rem_ff[0][j] <= rem_in[0][j];
         nlo_ff[0][j] <= nlo_in[0][j];
         ovf_ff[0][j] <= ovf_in[j];
         neg_ff[0][j] <= neg_in[j];
      end
      for (int s = 1; s <= K; s++) begin
         dd_ff[s]  <= dd_ff[s-1];
         sng_ff[s] <= sng_ff[s-1];
         for (int j = 0; j < NUM_ELEM; j++) begin
            rem_ff[s][j] <= rem_in[s][j];
            nlo_ff[s][j] <= nlo_in[s][j];
            ovf_ff[s][j] <= ovf_ff[s-1][j];
            neg_ff[s][j] <= neg_ff[s-1][j];
         end
      end
      for (int j = 0; j < NUM_ELEM; j++) begin
         res_ff[j] <= res_in[j];
      end
      sat_ff     <= sat_in;
      sng_out_ff <= sng_ff[K];
   end

   assign valid_out     = vld_out_ff;
   assign q_out         = res_ff;
   assign singular_out  = sng_out_ff;
   assign saturated_out = sat_ff;

endmodule

// ===== hw/rtl/normal_matrix_inverse_transpose_unit.sv =====
// Top level of the normal matrix (inverse transpose of a 3x3) unit.
//
// A request carries the nine column-major elements of a 3x3 matrix, signed
// fixed point with FRAC_BITS fraction bits. It is taken on a clock edge with
// start high and busy low; busy is always low, so a new request may enter on
// every cycle. Throughput: one request per cycle.
// From the accepting edge to the cycle in which rsp_valid is high, a request
// passes the cofactor stages (pair products, differences), the determinant
// stages (split products, recombine, sum, sign and magnitude), then a divider
// that resolves one quotient bit per stage over DATA_WIDTH + 1 stages plus an
// entry and an output stage.
// Each response is shown for exactly one cycle with rsp_valid high; the
// receiver cannot stall, and the pipeline never holds. rsp_singular flags a
// zero determinant (elements then zero); rsp_saturated flags a clamped
// element. Outputs are rounded to nearest, ties away from zero.
// Reset (synchronous) empties the pipeline: requests in flight are dropped
// and no response appears until new requests flow through.
module normal_matrix_inverse_transpose_unit import nmit_pkg::*; #(
   parameter int DATA_WIDTH = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_in_c0_r0,
   input  logic signed [DATA_WIDTH-1:0] req_in_c0_r1,
   input  logic signed [DATA_WIDTH-1:0] req_in_c0_r2,
   input  logic signed [DATA_WIDTH-1:0] req_in_c1_r0,
   input  logic signed [DATA_WIDTH-1:0] req_in_c1_r1,
   input  logic signed [DATA_WIDTH-1:0] req_in_c1_r2,
   input  logic signed [DATA_WIDTH-1:0] req_in_c2_r0,
   input  logic signed [DATA_WIDTH-1:0] req_in_c2_r1,
   input  logic signed [DATA_WIDTH-1:0] req_in_c2_r2,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c0_r0,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c0_r1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c0_r2,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c1_r0,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c1_r1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c1_r2,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c2_r0,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c2_r1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_c2_r2,
   output logic                         rsp_singular,
   output logic                         rsp_saturated
);
   localparam int W  = DATA_WIDTH;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam logic signed [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0]  m_w [NUM_ELEM];
   logic                 cof_vld;
   logic signed [CW-1:0] cof_w [NUM_ELEM];
   logic signed [W-1:0]  col_w [NUM_COL];
   nmit_det_ctl_type     det_ctl;
   logic signed [CW-1:0] cofd_w [NUM_ELEM];
   logic [DW-1:0]        dmag_w;
   logic signed [W-1:0]  q_w [NUM_ELEM];
   logic                 any_lim;
   logic                 all_zero;

   assign busy = 1'b0;

   assign m_w[0] = req_in_c0_r0;
   assign m_w[1] = req_in_c0_r1;
   assign m_w[2] = req_in_c0_r2;
   assign m_w[3] = req_in_c1_r0;
   assign m_w[4] = req_in_c1_r1;
   assign m_w[5] = req_in_c1_r2;
   assign m_w[6] = req_in_c2_r0;
   assign m_w[7] = req_in_c2_r1;
   assign m_w[8] = req_in_c2_r2;

   nmit_cofactor #(.W(W)) u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start & ~busy),
      .m_in      (m_w),
      .valid_out (cof_vld),
      .cof_out   (cof_w),
      .col_out   (col_w)
   );

   nmit_det #(.W(W)) u_det (
      .clock    (clock),
      .reset    (reset),
      .valid_in (cof_vld),
      .cof_in   (cof_w),
      .col_in   (col_w),
      .ctl_out  (det_ctl),
      .cof_out  (cofd_w),
      .dmag_out (dmag_w)
   );

   nmit_divider #(.W(W), .F(FRAC_BITS)) u_divider (
      .clock         (clock),
      .reset         (reset),
      .ctl_in        (det_ctl),
      .cof_in        (cofd_w),
      .dmag_in       (dmag_w),
      .valid_out     (rsp_valid),
      .q_out         (q_w),
      .singular_out  (rsp_singular),
      .saturated_out (rsp_saturated)
   );

   // cofactors are already in transposed positions
   assign rsp_out_c0_r0 = q_w[0];
   assign rsp_out_c0_r1 = q_w[1];
   assign rsp_out_c0_r2 = q_w[2];
   assign rsp_out_c1_r0 = q_w[3];
   assign rsp_out_c1_r1 = q_w[4];
   assign rsp_out_c1_r2 = q_w[5];
   assign rsp_out_c2_r0 = q_w[6];
   assign rsp_out_c2_r1 = q_w[7];
   assign rsp_out_c2_r2 = q_w[8];

   always_comb begin
      any_lim  = 1'b0;
      all_zero = 1'b1;
      for (int i = 0; i < NUM_ELEM; i++) begin
         any_lim  = any_lim | (q_w[i] == OUT_MAX) | (q_w[i] == OUT_MIN);
         all_zero = all_zero & (q_w[i] == '0);
      end
   end

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> all_zero)
      else $error("singular response with nonzero elements");

   a_singular_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated)
      else $error("singular response flagged saturated");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> any_lim)
      else $error("saturated flag without a clamped element");

endmodule
